// ===== hdl/owb_pkg.sv =====
// ---------------------------------------------------------------------------
// owb_pkg
// Shared types and constants of the 1-Wire bus master.
// ---------------------------------------------------------------------------
package owb_pkg;

  localparam int TIME_BITS = 10;
  localparam int BYTE_BITS = 8;
  localparam int BIT_IDX_W = $clog2(BYTE_BITS);
  localparam int REG_W     = 10;
  localparam int CFG_IDX_W = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [TIME_BITS-1:0] TICK_MAX = {TIME_BITS{1'b1}};
  localparam logic [BIT_IDX_W-1:0] BIT_LAST = BIT_IDX_W'(BYTE_BITS - 1);

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOV  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_START  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_HOLD   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_START   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_RECOV   = 4'd7;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_RST_LOW   = 10'b00_0000_0010,
    PH_RST_WAIT  = 10'b00_0000_0100,
    PH_RST_RECOV = 10'b00_0000_1000,
    PH_WR_LOW    = 10'b00_0001_0000,
    PH_WR_HOLD   = 10'b00_0010_0000,
    PH_WR_REL    = 10'b00_0100_0000,
    PH_RD_LOW    = 10'b00_1000_0000,
    PH_RD_WAIT   = 10'b01_0000_0000,
    PH_RD_RECOV  = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] reset_low;
    logic [REG_W-1:0] presence_wait;
    logic [REG_W-1:0] reset_recovery;
    logic [REG_W-1:0] write_start;
    logic [REG_W-1:0] write_hold;
    logic [REG_W-1:0] read_start;
    logic [REG_W-1:0] read_sample;
    logic [REG_W-1:0] read_recover;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 line_in;
  } item_t;

  typedef struct packed {
    logic                 drive_low;
    logic                 busy_res;
    logic                 done_res;
    logic                 presence_bit;
    logic [BYTE_BITS-1:0] read_byte;
  } result_t;

endpackage

// ===== hdl/one_wire_bus_master.sv =====
// ---------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master at standard speed, one item per bus tick.
// ---------------------------------------------------------------------------
// Each item on the in_ channel is one tick: the sampled bus level and an
// optional command (reset with presence detect, byte write, byte read).
// Every accepted item yields exactly one item on the out_ channel with the
// open-drain drive, busy and done flags, the presence sample and the last
// byte read. Commands that arrive while an operation runs are dropped.
// The user must load the timing registers through the cfg_ port only while
// idle; the block does not enforce this. Results are registered; one item
// can be taken every cycle unless the receiver stalls, since the sequencer
// state advances in a single pass. in_tready is high while the output
// register is empty or being drained, so a stalled receiver holds the
// current result and stops new input. Synchronous reset empties the output
// register, returns the sequencer to idle with presence high and the read
// byte zero, and restores the default timing values.
// ---------------------------------------------------------------------------
module one_wire_bus_master (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // mode[1:0], data_byte[9:2], line_in[10], zero fill
  input  logic [owb_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // drive_low[0], busy_res[1], done_res[2], presence_bit[3], read_byte[11:4]
  output logic [owb_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [owb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [owb_pkg::REG_W-1:0]       cfg_wdata
);
  import owb_pkg::*;

  cfg_t     cfg;
  item_t    item;
  result_t  res_nxt;
  result_t  res_r;
  logic     out_valid_r;
  logic     in_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign item.mode      = in_tdata[1:0];
  assign item.data_byte = in_tdata[9:2];
  assign item.line_in   = in_tdata[10];

  owb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  owb_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_acc),
    .item    (item),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.read_byte, res_r.presence_bit, res_r.done_res,
                       res_r.busy_res, res_r.drive_low};

endmodule

// ===== hdl/owb_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// owb_cfg_regs
// Timing register file, written through a plain write port.
// ---------------------------------------------------------------------------
module owb_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [owb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owb_pkg::REG_W-1:0]      cfg_wdata,
  output owb_pkg::cfg_t                  cfg
);
  import owb_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low      <= REG_W'(500);
      cfg_r.presence_wait  <= REG_W'(70);
      cfg_r.reset_recovery <= REG_W'(500);
      cfg_r.write_start    <= REG_W'(10);
      cfg_r.write_hold     <= REG_W'(50);
      cfg_r.read_start     <= REG_W'(5);
      cfg_r.read_sample    <= REG_W'(5);
      cfg_r.read_recover   <= REG_W'(50);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RESET_LOW:   cfg_r.reset_low      <= cfg_wdata;
        REG_PRESENCE_WT: cfg_r.presence_wait  <= cfg_wdata;
        REG_RESET_RECOV: cfg_r.reset_recovery <= cfg_wdata;
        REG_WRITE_START: cfg_r.write_start    <= cfg_wdata;
        REG_WRITE_HOLD:  cfg_r.write_hold     <= cfg_wdata;
        REG_READ_START:  cfg_r.read_start     <= cfg_wdata;
        REG_READ_SAMPLE: cfg_r.read_sample    <= cfg_wdata;
        REG_READ_RECOV:  cfg_r.read_recover   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/owb_core.sv =====
// ---------------------------------------------------------------------------
// owb_core
// Slot sequencer: phase, tick counter, bit index and shift byte, advanced
// by one tick for each accepted item.
// ---------------------------------------------------------------------------
module owb_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  owb_pkg::item_t    item,
  input  owb_pkg::cfg_t     cfg,
  output owb_pkg::result_t  res_nxt
);
  import owb_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [TIME_BITS-1:0]   cnt_r, cnt_nxt;
  logic [BIT_IDX_W-1:0]   bidx_r, bidx_nxt;
  logic [BYTE_BITS-1:0]   shift_r, shift_nxt;
  logic                   pres_r, pres_nxt;
  logic [BYTE_BITS-1:0]   last_r, last_nxt;

  logic [REG_W-1:0]       len;
  logic [TIME_BITS-1:0]   cnt_inc;
  logic                   ends;
  logic                   drive;
  logic                   busy;
  logic                   done;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bidx_nxt  = bidx_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    last_nxt  = last_r;
    drive     = 1'b0;
    done      = 1'b0;

    if (phase_r == PH_IDLE && item.mode != MODE_TICK) begin
      cnt_nxt  = '0;
      bidx_nxt = '0;
      case (item.mode)
        MODE_RESET: phase_nxt = PH_RST_LOW;
        MODE_WRITE: begin
          shift_nxt = item.data_byte;
          phase_nxt = PH_WR_LOW;
        end
        MODE_READ: begin
          shift_nxt = '0;
          phase_nxt = PH_RD_LOW;
        end
        default: ;
      endcase
    end

    busy = (phase_nxt != PH_IDLE);

    case (phase_nxt)
      PH_RST_LOW:   len = cfg.reset_low;
      PH_RST_WAIT:  len = cfg.presence_wait;
      PH_RST_RECOV: len = cfg.reset_recovery;
      PH_WR_LOW:    len = cfg.write_start;
      PH_WR_HOLD:   len = cfg.write_hold;
      PH_RD_LOW:    len = cfg.read_start;
      PH_RD_WAIT:   len = cfg.read_sample;
      PH_RD_RECOV:  len = cfg.read_recover;
      default:      len = '0;
    endcase

    cnt_inc = (cnt_nxt != TICK_MAX) ? cnt_nxt + TIME_BITS'(1) : cnt_nxt;
    ends    = (cnt_inc >= len) || (cnt_inc == TICK_MAX);

    case (phase_nxt)
      PH_IDLE: ;
      PH_RST_LOW: begin
        drive   = 1'b1;
        cnt_nxt = ends ? '0 : cnt_inc;
        if (ends) phase_nxt = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        cnt_nxt = ends ? '0 : cnt_inc;
        if (ends) begin
          pres_nxt  = item.line_in;
          phase_nxt = PH_RST_RECOV;
        end
      end
      PH_RST_RECOV: begin
        cnt_nxt = ends ? '0 : cnt_inc;
        if (ends) begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      PH_WR_LOW: begin
        drive   = 1'b1;
        cnt_nxt = ends ? '0 : cnt_inc;
        if (ends) phase_nxt = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        drive   = ~shift_nxt[bidx_nxt];
        cnt_nxt = ends ? '0 : cnt_inc;
        if (ends) phase_nxt = PH_WR_REL;
      end
      PH_WR_REL: begin
        cnt_nxt = '0;
        if (bidx_nxt == BIT_LAST) begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
          bidx_nxt  = '0;
        end else begin
          bidx_nxt  = bidx_nxt + BIT_IDX_W'(1);
          phase_nxt = PH_WR_LOW;
        end
      end
      PH_RD_LOW: begin
        drive   = 1'b1;
        cnt_nxt = ends ? '0 : cnt_inc;
        if (ends) phase_nxt = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        cnt_nxt = ends ? '0 : cnt_inc;
        if (ends) begin
          shift_nxt[bidx_nxt] = shift_nxt[bidx_nxt] | item.line_in;
          phase_nxt = PH_RD_RECOV;
        end
      end
      PH_RD_RECOV: begin
        cnt_nxt = ends ? '0 : cnt_inc;
        if (ends) begin
          if (bidx_nxt == BIT_LAST) begin
            done      = 1'b1;
            last_nxt  = shift_nxt;
            phase_nxt = PH_IDLE;
            bidx_nxt  = '0;
          end else begin
            bidx_nxt  = bidx_nxt + BIT_IDX_W'(1);
            phase_nxt = PH_RD_LOW;
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    res_nxt.drive_low    = drive;
    res_nxt.busy_res     = busy;
    res_nxt.done_res     = done;
    res_nxt.presence_bit = pres_nxt;
    res_nxt.read_byte    = last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bidx_r  <= '0;
      shift_r <= '0;
      pres_r  <= 1'b1;
      last_r  <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bidx_r  <= bidx_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ===== hdl/owb_checker.sv =====
// ---------------------------------------------------------------------------
// owb_checker
// Port-level checks of the 1-Wire bus master, bound to the top level.
// ---------------------------------------------------------------------------
module owb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [owb_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import owb_pkg::*;

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed");

  // With the output register empty the block must take input.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready while output empty");

  // Done only appears on a busy tick.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1])
    else $error("done without busy");

  // The bus is never pulled low while idle.
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("bus driven while idle");

endmodule

bind one_wire_bus_master owb_checker u_owb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/one_wire_bus_master_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// one_wire_bus_master_checker
// Watches both item channels and the timing register port of the 1-Wire
// master, runs its own model of the bus sequencer on every accepted tick and
// compares each result item, field by field, with the oldest prediction.
// It reports the number of failures, the number of results still due and
// whether the modeled sequencer is idle.
// ---------------------------------------------------------------------------
module one_wire_bus_master_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [owb_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [owb_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [owb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owb_pkg::REG_W-1:0]      cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output logic                           seq_idle
);
  import owb_pkg::*;

  phase_t                ph;
  logic [TIME_BITS-1:0]  tcnt;
  logic [BIT_IDX_W-1:0]  bidx;
  logic [BYTE_BITS-1:0]  sbyte;
  logic                  pres;
  logic [BYTE_BITS-1:0]  rd_last;
  logic [REG_W-1:0]      timing [8];
  result_t               results_due [$];
  int                    errors = 0;

  // A timed slot counts one tick and ends on its length or when the counter
  // saturates. A length of zero ends the slot on its first tick.
  function automatic logic slot_done(input logic [REG_W-1:0] len);
    if (tcnt != TICK_MAX) tcnt = tcnt + 1'b1;
    if (tcnt >= len || tcnt == TICK_MAX) begin
      tcnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t bus_tick(input item_t t);
    result_t r;
    r = '0;
    if (ph == PH_IDLE && t.mode != MODE_TICK) begin
      tcnt = '0;
      bidx = '0;
      case (t.mode)
        MODE_RESET: ph = PH_RST_LOW;
        MODE_WRITE: begin
          sbyte = t.data_byte;
          ph    = PH_WR_LOW;
        end
        default: begin
          sbyte = '0;
          ph    = PH_RD_LOW;
        end
      endcase
    end
    r.busy_res = (ph != PH_IDLE);
    case (ph)
      PH_IDLE: ;
      PH_RST_LOW: begin
        r.drive_low = 1'b1;
        if (slot_done(timing[REG_RESET_LOW])) ph = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        if (slot_done(timing[REG_PRESENCE_WT])) begin
          pres = t.line_in;
          ph   = PH_RST_RECOV;
        end
      end
      PH_RST_RECOV: begin
        if (slot_done(timing[REG_RESET_RECOV])) begin
          r.done_res = 1'b1;
          ph         = PH_IDLE;
        end
      end
      PH_WR_LOW: begin
        r.drive_low = 1'b1;
        if (slot_done(timing[REG_WRITE_START])) ph = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        r.drive_low = ~sbyte[bidx];
        if (slot_done(timing[REG_WRITE_HOLD])) ph = PH_WR_REL;
      end
      PH_WR_REL: begin
        tcnt = '0;
        if (bidx == BIT_LAST) begin
          r.done_res = 1'b1;
          ph         = PH_IDLE;
          bidx       = '0;
        end else begin
          bidx = bidx + 1'b1;
          ph   = PH_WR_LOW;
        end
      end
      PH_RD_LOW: begin
        r.drive_low = 1'b1;
        if (slot_done(timing[REG_READ_START])) ph = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        if (slot_done(timing[REG_READ_SAMPLE])) begin
          sbyte[bidx] = sbyte[bidx] | t.line_in;
          ph          = PH_RD_RECOV;
        end
      end
      PH_RD_RECOV: begin
        if (slot_done(timing[REG_READ_RECOV])) begin
          if (bidx == BIT_LAST) begin
            r.done_res = 1'b1;
            rd_last    = sbyte;
            ph         = PH_IDLE;
            bidx       = '0;
          end else begin
            bidx = bidx + 1'b1;
            ph   = PH_RD_LOW;
          end
        end
      end
      default: ph = PH_IDLE;
    endcase
    r.presence_bit = pres;
    r.read_byte    = rd_last;
    return r;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    item_t   t;
    result_t seen;
    result_t due;
    if (!rst_n) begin
      ph      = PH_IDLE;
      tcnt    = '0;
      bidx    = '0;
      sbyte   = '0;
      pres    = 1'b1;
      rd_last = '0;
      timing[REG_RESET_LOW]   = 10'd500;
      timing[REG_PRESENCE_WT] = 10'd70;
      timing[REG_RESET_RECOV] = 10'd500;
      timing[REG_WRITE_START] = 10'd10;
      timing[REG_WRITE_HOLD]  = 10'd50;
      timing[REG_READ_START]  = 10'd5;
      timing[REG_READ_SAMPLE] = 10'd5;
      timing[REG_READ_RECOV]  = 10'd50;
      results_due.delete();
    end else begin
      if (cfg_wr_en && cfg_index <= REG_READ_RECOV) timing[cfg_index] = cfg_wdata;
      if (out_tvalid && out_tready) begin
        seen.drive_low    = out_tdata[0];
        seen.busy_res     = out_tdata[1];
        seen.done_res     = out_tdata[2];
        seen.presence_bit = out_tdata[3];
        seen.read_byte    = out_tdata[11:4];
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t ns: result expected none, got %h", $time, out_tdata);
        end else begin
          due = results_due.pop_front();
          check_field("drive_low", due.drive_low, seen.drive_low);
          check_field("busy_res", due.busy_res, seen.busy_res);
          check_field("done_res", due.done_res, seen.done_res);
          check_field("presence_bit", due.presence_bit, seen.presence_bit);
          check_field("read_byte", due.read_byte, seen.read_byte);
        end
      end
      if (in_tvalid && in_tready) begin
        t.mode      = in_tdata[1:0];
        t.data_byte = in_tdata[9:2];
        t.line_in   = in_tdata[10];
        results_due.push_back(bus_tick(t));
      end
    end
    pending    <= results_due.size();
    seq_idle   <= (ph == PH_IDLE);
    fail_count <= errors;
  end

endmodule

// ===== tb/tb_one_wire_bus_master.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_one_wire_bus_master
// Stimulus and verdict for the 1-Wire bus master.
// Drives bus ticks with resets, byte writes and byte reads under the reset
// write timing, all-zero timing and many short random timings, with
// random gaps on both channels, a long receiver hold-off and a full drain.
// A separate checker predicts and compares every result item.
// ---------------------------------------------------------------------------
module tb_one_wire_bus_master;
  import owb_pkg::*;

  typedef enum int {GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH} gap_mode_t;
  typedef enum int {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_drive_t;
  typedef enum int {TIMING_ZERO, TIMING_TINY, TIMING_SHORT} timing_kind_t;

  localparam int PHASES         = 8;
  localparam int RUN_ITEMS      = 75;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_PAUSE    = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 4'd8;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [REG_W-1:0]      cfg_wdata  = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    fail_count;
  int                    pending;
  logic                  seq_idle;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  one_wire_bus_master DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  one_wire_bus_master_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .seq_idle   (seq_idle)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_one_wire_bus_master NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_gaps(input gap_mode_t m);
    case (m)
      GAPS_NONE: begin
        tx_idle_pct  <= 0;
        rx_stall_pct <= 0;
      end
      GAPS_SENDER: begin
        tx_idle_pct  <= 52;
        rx_stall_pct <= 0;
      end
      GAPS_RECEIVER: begin
        tx_idle_pct  <= 0;
        rx_stall_pct <= 52;
      end
      default: begin
        tx_idle_pct  <= 30;
        rx_stall_pct <= 30;
      end
    endcase
  endtask

  task automatic send_item(input logic [1:0] mode, input logic [7:0] data, input logic line);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - 11){1'b0}}, line, data, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random();
    logic [1:0] mode;
    mode = MODE_TICK;
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 2))
        0: mode = MODE_RESET;
        1: mode = MODE_WRITE;
        default: mode = MODE_READ;
      endcase
    end
    send_item(mode, 8'($urandom), 1'($urandom));
  endtask

  // Ticks the bus until the running operation is over, then lets every
  // result drain before returning with the input channel quiet.
  task automatic settle(input line_drive_t how);
    logic line;
    do begin
      case (how)
        LINE_LOW:  line = 1'b0;
        LINE_HIGH: line = 1'b1;
        default:   line = 1'($urandom);
      endcase
      send_item(MODE_TICK, 8'($urandom), line);
    end while (!seq_idle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic load_timing(input timing_kind_t kind);
    logic [REG_W-1:0] val;
    for (int r = REG_RESET_LOW; r <= REG_READ_RECOV; r++) begin
      case (kind)
        TIMING_ZERO: val = '0;
        TIMING_TINY: val = REG_W'($urandom_range(0, 3));
        default:     val = REG_W'($urandom_range(0, 12));
      endcase
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_wdata <= val;
      @(posedge clk);
    end
    // A write past the last register must leave the timing untouched.
    cfg_index <= REG_COUNT + CFG_IDX_W'($urandom_range(0, 7));
    cfg_wdata <= REG_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset timing: one byte write with the default slot lengths.
    send_item(MODE_WRITE, 8'hA5, 1'b1);
    settle(LINE_HIGH);

    // Zero timing runs every slot for one tick; commands on busy and
    // finishing ticks are dropped.
    load_timing(TIMING_ZERO);
    send_item(MODE_RESET, 8'hFF, 1'b1);
    send_item(MODE_WRITE, 8'hFF, 1'b0);
    send_item(MODE_READ, 8'h00, 1'b1);
    send_item(MODE_WRITE, 8'hFF, 1'b0);
    settle(LINE_HIGH);
    send_item(MODE_WRITE, 8'h00, 1'b1);
    settle(LINE_LOW);
    send_item(MODE_READ, 8'h00, 1'b1);
    settle(LINE_HIGH);
    send_item(MODE_READ, 8'hFF, 1'b0);
    settle(LINE_LOW);

    for (int p = 0; p < PHASES; p++) begin
      load_timing((p % 2 == 1) ? TIMING_TINY : TIMING_SHORT);
      set_gaps(gap_mode_t'(p % 4));
      for (int n = 0; n < RUN_ITEMS; n++) begin
        if (p == 0 && n == 20) hold_req <= hold_req + 1;
        if (p == 5 && n == RUN_ITEMS / 2) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_random();
      end
      settle(LINE_RANDOM);
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb_one_wire_bus_master OK");
    end else begin
      $display("tb_one_wire_bus_master NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/owb_pkg.sv
hdl/owb_cfg_regs.sv
hdl/owb_core.sv
hdl/one_wire_bus_master.sv
hdl/owb_checker.sv
tb/one_wire_bus_master_checker.sv
tb/tb_one_wire_bus_master.sv
